@@ hw/rtl/rtfp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtfp_pkg
// shared types and constants of the radar tlv frame parser
// ----------------------------------------------------------------------------
package rtfp_pkg;

  localparam int          MaxPointCountDefault = 256;
  localparam logic [31:0] HeaderBytes          = 32'd40;
  localparam logic [63:0] MagicPattern         = 64'h0201040306050807;
  localparam logic [31:0] UnitBytes            = 32'd20;
  localparam logic [31:0] TlvHeadBytes         = 32'd8;
  localparam logic [31:0] PresenceBytes        = 32'd4;

  localparam logic [2:0] KIND_HEADER   = 3'd0;
  localparam logic [2:0] KIND_UNIT     = 3'd1;
  localparam logic [2:0] KIND_POINT    = 3'd2;
  localparam logic [2:0] KIND_RAW      = 3'd3;
  localparam logic [2:0] KIND_PRESENCE = 3'd4;
  localparam logic [2:0] KIND_HEAD_OVR = 3'd5;
  localparam logic [2:0] KIND_PAY_OVR  = 3'd6;
  localparam logic [2:0] KIND_SHORT    = 3'd7;

  localparam logic [1:0] PH_HUNT    = 2'd0;
  localparam logic [1:0] PH_HEADER  = 2'd1;
  localparam logic [1:0] PH_HEAD    = 2'd2;
  localparam logic [1:0] PH_PAYLOAD = 2'd3;

  localparam logic REG_POINT_CLOUD = 1'b0;
  localparam logic REG_PRESENCE    = 1'b1;

  typedef struct packed {
    logic              frame_done;
    logic signed [15:0] snr;
    logic signed [15:0] range_steps;
    logic signed [15:0] doppler;
    logic signed [7:0]  azimuth;
    logic signed [7:0]  elevation;
    logic [31:0]        word;
    logic [31:0]        item_index;
    logic [31:0]        tlv_type;
    logic [31:0]        frame_number;
    logic [2:0]         kind;
  } result_t;

endpackage

@@ hw/rtl/radar_tlv_frame_parser_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radar_tlv_frame_parser_unit
// byte stream parser: magic word hunt, header words, tlv decoding
// ----------------------------------------------------------------------------
// output: results are registered; each appears in the cycle after the byte that causes it is taken
// throughput: one byte per cycle while the output register is empty or m_tready is high,
//   set by the single output register that is refilled in the same cycle it is drained
// reset: synchronous; parser hunts for the magic word, all counters zero,
//   type registers take 1020 and 1021
module radar_tlv_frame_parser_unit #(
  parameter int MAX_POINT_COUNT = rtfp_pkg::MaxPointCountDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // byte_in
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [191:0] m_tdata,   // frame_number, tlv_type, item_index, word,
                                  // elevation, azimuth, doppler, range_steps, snr
  output logic         m_tlast,   // frame_done
  output logic [2:0]   m_tuser    // kind
);

  localparam int PW = $clog2(MAX_POINT_COUNT + 1);

  logic [31:0] point_cloud_type, presence_type;
  logic [63:0] magic_window;
  logic [1:0]  phase;
  logic [4:0]  byte_counter;
  logic [31:0] assemble_word, tlvs_left, region_len, region_offset;
  logic [31:0] current_type, current_length, payload_count, frame_id;
  logic [55:0] point_bytes;
  logic [PW-1:0] points_emitted;

  logic [63:0] magic_window_next;
  logic [1:0]  phase_next;
  logic [4:0]  byte_counter_next;
  logic [31:0] assemble_word_next, tlvs_left_next, region_len_next;
  logic [31:0] region_offset_next, current_type_next, current_length_next;
  logic [31:0] payload_count_next, frame_id_next;
  logic [55:0] point_bytes_next;
  logic [PW-1:0] points_emitted_next;

  rtfp_pkg::result_t res, res_q;
  logic have;
  logic out_full;
  logic take;

  assign s_tready = !out_full || m_tready;
  assign take     = s_tvalid && s_tready;

  always_comb begin
    logic [31:0] aw, ro8, fin_off, o;
    logic [32:0] sum;
    logic [2:0]  j;
    logic        is_pc, is_short, fin_last;
    aw = {s_tdata, assemble_word[31:8]};
    ro8 = '0; fin_off = '0; o = '0; sum = '0; j = '0;
    is_pc = 1'b0; is_short = 1'b0; fin_last = 1'b0;
    magic_window_next   = magic_window;
    phase_next          = phase;
    byte_counter_next   = byte_counter;
    assemble_word_next  = assemble_word;
    tlvs_left_next      = tlvs_left;
    region_len_next     = region_len;
    region_offset_next  = region_offset;
    current_type_next   = current_type;
    current_length_next = current_length;
    payload_count_next  = payload_count;
    frame_id_next       = frame_id;
    point_bytes_next    = point_bytes;
    points_emitted_next = points_emitted;
    have = 1'b0;
    res  = '0;
    res.frame_number = frame_id;
    unique case (phase)
      rtfp_pkg::PH_HUNT: begin
        magic_window_next = {magic_window[55:0], s_tdata};
        if (magic_window_next == rtfp_pkg::MagicPattern) begin
          magic_window_next  = '0;
          phase_next         = rtfp_pkg::PH_HEADER;
          byte_counter_next  = '0;
          assemble_word_next = '0;
          frame_id_next      = '0;
          current_type_next  = '0;
        end
      end
      rtfp_pkg::PH_HEADER: begin
        assemble_word_next = aw;
        byte_counter_next  = byte_counter + 5'd1;
        if (byte_counter[1:0] == 2'd3) begin
          have = 1'b1;
          res.kind = rtfp_pkg::KIND_HEADER;
          res.item_index = {29'd0, byte_counter[4:2]};
          res.word = aw;
          if (byte_counter[4:2] == 3'd1)
            region_len_next = (aw > rtfp_pkg::HeaderBytes) ?
                              aw - rtfp_pkg::HeaderBytes : '0;
          if (byte_counter[4:2] == 3'd3) begin
            frame_id_next = aw;
            res.frame_number = aw;
          end
          if (byte_counter[4:2] == 3'd6) tlvs_left_next = aw;
          if (byte_counter[4:2] == 3'd7) begin
            region_offset_next = '0;
            byte_counter_next  = '0;
            if (tlvs_left == '0) begin
              phase_next = rtfp_pkg::PH_HUNT;
              res.frame_done = 1'b1;
            end else begin
              phase_next = rtfp_pkg::PH_HEAD;
            end
          end
        end
      end
      rtfp_pkg::PH_HEAD: begin
        sum = {1'b0, region_offset} + {1'b0, rtfp_pkg::TlvHeadBytes};
        if (byte_counter[2:0] == 3'd0 && sum > {1'b0, region_len}) begin
          phase_next = rtfp_pkg::PH_HUNT;
          have = 1'b1;
          res.kind = rtfp_pkg::KIND_HEAD_OVR;
          res.item_index = region_offset;
          res.frame_done = 1'b1;
        end else begin
          assemble_word_next = aw;
          byte_counter_next  = {2'd0, byte_counter[2:0] + 3'd1};
          if (byte_counter[2:0] == 3'd3) current_type_next = aw;
          if (byte_counter[2:0] == 3'd7) begin
            current_length_next = aw;
            ro8 = sum[31:0];
            region_offset_next = ro8;
            sum = {1'b0, ro8} + {1'b0, aw};
            if (sum > {1'b0, region_len}) begin
              phase_next = rtfp_pkg::PH_HUNT;
              have = 1'b1;
              res.kind = rtfp_pkg::KIND_PAY_OVR;
              res.tlv_type = current_type;
              res.item_index = ro8;
              res.word = aw;
              res.frame_done = 1'b1;
            end else begin
              payload_count_next  = '0;
              points_emitted_next = '0;
              point_bytes_next    = '0;
              is_short = (current_type == point_cloud_type) && (aw < rtfp_pkg::UnitBytes);
              res.kind = rtfp_pkg::KIND_SHORT;
              res.tlv_type = current_type;
              res.word = aw;
              have = is_short;
              if (aw == '0) begin
                region_offset_next = ro8;
                tlvs_left_next = tlvs_left - 32'd1;
                if (tlvs_left == 32'd1) begin
                  phase_next = rtfp_pkg::PH_HUNT;
                  res.frame_done = 1'b1;
                end else begin
                  phase_next = rtfp_pkg::PH_HEAD;
                  byte_counter_next = '0;
                end
              end else begin
                phase_next = rtfp_pkg::PH_PAYLOAD;
              end
            end
          end
        end
      end
      default: begin
        o = payload_count;
        payload_count_next = o + 32'd1;
        res.tlv_type = current_type;
        is_pc = current_type == point_cloud_type;
        if (is_pc) begin
          if (current_length >= rtfp_pkg::UnitBytes) begin
            if (o < rtfp_pkg::UnitBytes) begin
              assemble_word_next = aw;
              if (o[1:0] == 2'd3) begin
                have = 1'b1;
                res.kind = rtfp_pkg::KIND_UNIT;
                res.item_index = {2'd0, o[31:2]};
                res.word = aw;
              end
            end else begin
              fin_off = o - rtfp_pkg::UnitBytes;
              j = fin_off[2:0];
              if (j != 3'd7) begin
                for (int i = 0; i < 7; i++)
                  if (j == 3'(i)) point_bytes_next[8*i +: 8] = s_tdata;
              end else if (32'(points_emitted) < 32'(MAX_POINT_COUNT)) begin
                have = 1'b1;
                res.kind = rtfp_pkg::KIND_POINT;
                res.item_index = 32'(points_emitted);
                points_emitted_next = points_emitted + PW'(1);
                res.elevation   = point_bytes[7:0];
                res.azimuth     = point_bytes[15:8];
                res.doppler     = point_bytes[31:16];
                res.range_steps = point_bytes[47:32];
                res.snr         = {s_tdata, point_bytes[55:48]};
              end
            end
          end
        end else if (current_type == presence_type) begin
          if (o < rtfp_pkg::PresenceBytes) begin
            assemble_word_next = aw;
            if (o == 32'd3 && current_length >= rtfp_pkg::PresenceBytes) begin
              have = 1'b1;
              res.kind = rtfp_pkg::KIND_PRESENCE;
              res.item_index = o;
              res.word = aw;
            end
          end
        end else begin
          have = 1'b1;
          res.kind = rtfp_pkg::KIND_RAW;
          res.item_index = o;
          res.word = {24'd0, s_tdata};
        end
        if (payload_count_next == current_length) begin
          region_offset_next = region_offset + current_length;
          tlvs_left_next = tlvs_left - 32'd1;
          fin_last = tlvs_left == 32'd1;
          if (fin_last) begin
            phase_next = rtfp_pkg::PH_HUNT;
            res.frame_done = 1'b1;
          end else begin
            phase_next = rtfp_pkg::PH_HEAD;
            byte_counter_next = '0;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      point_cloud_type <= 32'd1020;
      presence_type    <= 32'd1021;
      magic_window     <= '0;
      phase            <= rtfp_pkg::PH_HUNT;
      byte_counter     <= '0;
      assemble_word    <= '0;
      tlvs_left        <= '0;
      region_len       <= '0;
      region_offset    <= '0;
      current_type     <= '0;
      current_length   <= '0;
      payload_count    <= '0;
      frame_id         <= '0;
      point_bytes      <= '0;
      points_emitted   <= '0;
      out_full         <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == rtfp_pkg::REG_POINT_CLOUD) point_cloud_type <= cfg_data;
        if (cfg_index == rtfp_pkg::REG_PRESENCE)    presence_type    <= cfg_data;
      end
      if (take) begin
        magic_window   <= magic_window_next;
        phase          <= phase_next;
        byte_counter   <= byte_counter_next;
        assemble_word  <= assemble_word_next;
        tlvs_left      <= tlvs_left_next;
        region_len     <= region_len_next;
        region_offset  <= region_offset_next;
        current_type   <= current_type_next;
        current_length <= current_length_next;
        payload_count  <= payload_count_next;
        frame_id       <= frame_id_next;
        point_bytes    <= point_bytes_next;
        points_emitted <= points_emitted_next;
        out_full       <= have;
      end else if (m_tready) begin
        out_full <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && have) res_q <= res;
  end

  assign m_tvalid = out_full;
  assign m_tuser  = res_q.kind;
  assign m_tlast  = res_q.frame_done;
  assign m_tdata  = {res_q.snr, res_q.range_steps, res_q.doppler, res_q.azimuth,
                     res_q.elevation, res_q.word, res_q.item_index, res_q.tlv_type,
                     res_q.frame_number};

endmodule
